### hw/rtl/gdpc_pkg.sv
// gdpc_pkg: widths shared by the gcd / distinct prime count block
// no dependencies; used by gdpc_div and gcd_distinct_prime_count
`default_nettype none

package gdpc_pkg;

   localparam int OPERAND_WIDTH = 40;
   localparam int COUNT_WIDTH   = 5;
   // bit counter of the serial divider, holds OPERAND_WIDTH itself
   localparam int STEP_WIDTH    = $clog2(OPERAND_WIDTH + 1);

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;
   typedef logic [STEP_WIDTH-1:0]    step_type;

endpackage

`default_nettype wire

### hw/rtl/gcd_distinct_prime_count.sv
// gcd_distinct_prime_count: one plus the number of distinct primes dividing gcd(a, b)
// Euclid steps, then factors of two shifted out, then trial division; each Euclid or trial
// step is one serial division, up to about 2^19 trial divisions for 40-bit operands
// a zero operand gives a registered result of 1 in the cycle after the transaction is taken
// one transaction at a time, busy high until the result strobe; sync reset clears control
`default_nettype none

module gcd_distinct_prime_count (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire gdpc_pkg::operand_type req_first_value,
   input  wire gdpc_pkg::operand_type req_second_value,
   output logic                       rsp_strobe,
   output gdpc_pkg::count_type        rsp_coprime_count
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_GCD    = 3'd1;
   localparam logic [2:0] S_EVEN   = 3'd2;
   localparam logic [2:0] S_TRIAL  = 3'd3;
   localparam logic [2:0] S_DIVOUT = 3'd4;

   logic [2:0]            state_ff, state_in;
   gdpc_pkg::operand_type x_ff, x_in;   // gcd operand, later the remaining cofactor
   gdpc_pkg::operand_type y_ff, y_in;   // gcd operand, later the trial divisor
   gdpc_pkg::count_type   cnt_ff, cnt_in;
   logic                  div_start_ff, div_start_in;
   logic                  strobe_ff, strobe_in;
   gdpc_pkg::count_type   rsp_cnt_ff, rsp_cnt_in;

   logic                  div_done;
   gdpc_pkg::operand_type div_quo;
   gdpc_pkg::operand_type div_rem;

   gdpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (x_ff),
      .divisor   (y_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      div_start_in = 1'b0;
      strobe_in    = 1'b0;
      rsp_cnt_in   = rsp_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_first_value == '0 || req_second_value == '0) begin
                  strobe_in  = 1'b1;
                  rsp_cnt_in = gdpc_pkg::COUNT_WIDTH'(1);
               end else begin
                  x_in         = req_first_value;
                  y_in         = req_second_value;
                  cnt_in       = gdpc_pkg::COUNT_WIDTH'(1);
                  div_start_in = 1'b1;
                  state_in     = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (div_done) begin
               x_in = y_ff;
               y_in = div_rem;
               if (div_rem == '0) begin
                  // gcd found; a factor of two counts once
                  if (!y_ff[0]) begin
                     cnt_in = cnt_ff + gdpc_pkg::COUNT_WIDTH'(1);
                  end
                  state_in = S_EVEN;
               end else begin
                  div_start_in = 1'b1;
               end
            end
         end
         S_EVEN: begin
            if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else begin
               y_in         = gdpc_pkg::OPERAND_WIDTH'(3);
               div_start_in = 1'b1;
               state_in     = S_TRIAL;
            end
         end
         S_TRIAL: begin
            if (div_done) begin
               priority if (y_ff > div_quo) begin
                  // divisor past the square root: what is left is one prime or one
                  strobe_in  = 1'b1;
                  rsp_cnt_in = cnt_ff + gdpc_pkg::COUNT_WIDTH'(x_ff > gdpc_pkg::OPERAND_WIDTH'(1));
                  state_in   = S_IDLE;
               end else if (div_rem == '0) begin
                  cnt_in       = cnt_ff + gdpc_pkg::COUNT_WIDTH'(1);
                  x_in         = div_quo;
                  div_start_in = 1'b1;
                  state_in     = S_DIVOUT;
               end else begin
                  y_in         = y_ff + gdpc_pkg::OPERAND_WIDTH'(2);
                  div_start_in = 1'b1;
               end
            end
         end
         S_DIVOUT: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  x_in = div_quo;
               end else begin
                  y_in     = y_ff + gdpc_pkg::OPERAND_WIDTH'(2);
                  state_in = S_TRIAL;
               end
               div_start_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         strobe_ff    <= strobe_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      cnt_ff     <= cnt_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_coprime_count = rsp_cnt_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == S_IDLE && rsp_cnt_ff != '0))
      else $error("result strobe outside idle or with zero count");

   a_trial_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRIAL || state_ff == S_DIVOUT) |-> (y_ff[0] && y_ff >= 3))
      else $error("trial divisor not odd or below three");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> busy)
      else $error("division started while idle");

endmodule

`default_nettype wire

### hw/rtl/gdpc_div.sv
// gdpc_div: restoring divider, one quotient bit per cycle
// dividend shifts out msb first while quotient bits shift in; uses gdpc_pkg
`default_nettype none

module gdpc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire gdpc_pkg::operand_type dividend,
   input  wire gdpc_pkg::operand_type divisor,
   output logic                       done,
   output gdpc_pkg::operand_type      quotient,
   output gdpc_pkg::operand_type      remainder
);

   gdpc_pkg::operand_type quo_ff, quo_in;
   gdpc_pkg::operand_type rem_ff, rem_in;
   gdpc_pkg::operand_type dsr_ff, dsr_in;
   gdpc_pkg::step_type    step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [gdpc_pkg::OPERAND_WIDTH:0] trial;
   logic [gdpc_pkg::OPERAND_WIDTH:0] diff;
   logic                             fits;

   assign trial = {rem_ff, quo_ff[gdpc_pkg::OPERAND_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = gdpc_pkg::STEP_WIDTH'(gdpc_pkg::OPERAND_WIDTH);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? diff[gdpc_pkg::OPERAND_WIDTH-1:0]
                        : trial[gdpc_pkg::OPERAND_WIDTH-1:0];
         quo_in  = {quo_ff[gdpc_pkg::OPERAND_WIDTH-2:0], fits};
         step_in = step_ff - gdpc_pkg::STEP_WIDTH'(1);
         if (step_ff == gdpc_pkg::STEP_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // remainder stays below the divisor once a division has finished
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(run_ff) && !run_ff))
      else $error("divider done without a finished run");

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench for gcd_distinct_prime_count: directed and random operand pairs
// predicts one plus the distinct prime count of the gcd and checks every result
// depends on gdpc_pkg and the gcd_distinct_prime_count rtl

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned OPERAND_MAX = (64'd1 << gdpc_pkg::OPERAND_WIDTH) - 64'd1;
   // longest trial run here is a few hundred serial divisions
   localparam int unsigned STALL_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 50;
   // product of the first eleven primes, the most distinct primes that fit in 40 bits
   localparam longint unsigned PRIMORIAL_11 = 64'd200560490130;

   typedef struct {
      gdpc_pkg::operand_type first_value;
      gdpc_pkg::operand_type second_value;
      gdpc_pkg::count_type   coprime_count;
   } gcd_expectation_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   gdpc_pkg::operand_type req_first_value = '0;
   gdpc_pkg::operand_type req_second_value = '0;
   logic                  rsp_strobe;
   gdpc_pkg::count_type   rsp_coprime_count;

   gcd_expectation_type pending_counts[$];
   int unsigned         pairs_sent = 0;
   int unsigned         directed_pairs = 0;
   int unsigned         counts_checked = 0;
   int unsigned         error_count = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         highest_count = 0;
   bit                  pacing_on = 1'b1;

   int unsigned small_primes[$] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
      73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
      157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233,
      239, 241, 251};
   // at most one of these per gcd keeps trial division short
   int unsigned big_primes[$] = '{257, 1021, 4093, 65519, 65521, 1000003};

   gcd_distinct_prime_count dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_coprime_count (rsp_coprime_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic gdpc_pkg::count_type predict_coprime_count(gdpc_pkg::operand_type a,
                                                                 gdpc_pkg::operand_type b);
      longint unsigned x;
      longint unsigned y;
      longint unsigned rem;
      longint unsigned g;
      longint unsigned d;
      longint unsigned primes;
      if (a == '0 || b == '0) begin
         return gdpc_pkg::count_type'(1);
      end
      x = 64'(a);
      y = 64'(b);
      while (y != 0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      g = x;
      primes = 0;
      if (g[0] == 1'b0) begin
         primes++;
         while (g[0] == 1'b0) g = g >> 1;
      end
      for (d = 3; d <= g / d; d += 2) begin
         if (g % d == 0) begin
            primes++;
            while (g % d == 0) g = g / d;
         end
      end
      if (g > 1) primes++;
      return gdpc_pkg::count_type'(primes + 1);
   endfunction

   function automatic longint unsigned random_operand();
      return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
   endfunction

   // one transaction: random gap when pacing is on, then hold start until busy is seen low at an edge
   task automatic send_operands(input longint unsigned a, input longint unsigned b);
      int unsigned         gap;
      gcd_expectation_type entry;
      gap = pacing_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_first_value <= gdpc_pkg::operand_type'(a);
      req_second_value <= gdpc_pkg::operand_type'(b);
      do @(posedge clock); while (busy);
      entry.first_value = gdpc_pkg::operand_type'(a);
      entry.second_value = gdpc_pkg::operand_type'(b);
      entry.coprime_count = predict_coprime_count(entry.first_value, entry.second_value);
      pending_counts.insert(pending_counts.size(), entry);
      pairs_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      pacing_on = 1'b1;
      send_operands(1, 1);
      send_operands(OPERAND_MAX, OPERAND_MAX);
      send_operands(1, OPERAND_MAX);
      send_operands(OPERAND_MAX, 1);
      send_operands(OPERAND_MAX, OPERAND_MAX - 1);
      send_operands(64'h80_0000_0000, 64'h80_0000_0000);
      send_operands(64'h80_0000_0000, 6);
      send_operands(PRIMORIAL_11, PRIMORIAL_11);
      send_operands(PRIMORIAL_11, PRIMORIAL_11 * 5);
      send_operands(64'hAA_AAAA_AAAA, 64'h55_5555_5555);
      // consecutive fibonacci numbers give the longest euclid chain
      send_operands(64'd956722026041, 64'd591286729879);
      send_operands(64'd1000003 * 3, 64'd1000003 * 7);
      send_operands(64'd847288609443, 64'd3486784401);
      send_operands(64'd65521 * 251 * 2, 64'd65521 * 4);
      send_operands(64'd251 * 251 * 8, 64'd251 * 251 * 9);
      pacing_on = 1'b0;
      send_operands(12, 18);
      send_operands(97, 97);
      send_operands(1024, 3072);
      directed_pairs = pairs_sent;
   endtask

   task automatic test_zero_operands();
      pacing_on = 1'b1;
      send_operands(0, 12);
      send_operands(12, 0);
      send_operands(0, 0);
      pacing_on = 1'b0;
      send_operands(0, OPERAND_MAX);
      send_operands(OPERAND_MAX, 0);
      directed_pairs = pairs_sent;
   endtask

   // operands are g*u and g*(u-1) when u > 1, so the gcd is then exactly the built common factor
   task automatic test_random_common_factor(input int unsigned count);
      longint unsigned g;
      longint unsigned p;
      longint unsigned u;
      longint unsigned v;
      longint unsigned reach;
      int unsigned     n;
      int unsigned     k;
      int unsigned     e;
      for (n = 0; n < count; n++) begin
         if (n % 12 == 0) pacing_on = ($urandom_range(0, 2) != 0);
         if (n == count / 2) wait_for_results();
         g = 1;
         if ($urandom_range(0, 4) == 0) begin
            for (k = $urandom_range(1, 11); k != 0; k--) g = g * small_primes[k - 1];
         end else begin
            for (k = $urandom_range(0, 6); k != 0; k--) begin
               p = 64'(small_primes[$urandom_range(0, small_primes.size() - 1)]);
               for (e = $urandom_range(1, 3); e != 0; e--) begin
                  if (g * p <= OPERAND_MAX / 4) g = g * p;
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               p = 64'(big_primes[$urandom_range(0, big_primes.size() - 1)]);
               if (g * p <= OPERAND_MAX) g = g * p;
            end
         end
         reach = OPERAND_MAX / g;
         u = (random_operand() % reach) + 1;
         v = (u > 1) ? u - 1 : (random_operand() % reach) + 1;
         if ($urandom_range(0, 1) == 0) send_operands(g * u, g * v);
         else send_operands(g * v, g * u);
      end
   endtask

   task automatic test_random_noise(input int unsigned count);
      longint unsigned a;
      longint unsigned b;
      int unsigned     n;
      pacing_on = 1'b1;
      for (n = 0; n < count; n++) begin
         a = ($urandom_range(0, 9) == 0) ? 64'd0 : random_operand();
         b = ($urandom_range(0, 9) == 0) ? 64'd0 : random_operand();
         send_operands(a, b);
      end
   endtask

   always @(posedge clock) begin
      gcd_expectation_type oldest;
      if (!reset && rsp_strobe) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected result, expected none, got coprime_count %0d",
                     $time, rsp_coprime_count);
            error_count++;
         end else begin
            oldest = pending_counts.pop_front();
            counts_checked++;
            if (32'(rsp_coprime_count) > highest_count) begin
               highest_count = 32'(rsp_coprime_count);
            end
            if (rsp_coprime_count !== oldest.coprime_count) begin
               $display("%0t: coprime_count mismatch for a=%0d b=%0d: expected %0d, got %0d",
                        $time, oldest.first_value, oldest.second_value,
                        oldest.coprime_count, rsp_coprime_count);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction taken and no result seen
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, pending_counts.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_zero_operands();
      wait_for_results();
      test_random_common_factor(52);
      test_random_noise(25);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d of %0d operand pairs (%0d directed, rest random)",
               counts_checked, pairs_sent, directed_pairs);
      $display("largest coprime count returned: %0d", highest_count);
      if (error_count == 0 && pending_counts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
